/* sv/ppts_pkg.sv */
package ppts_pkg;

    localparam int W_COORD = 32;
    localparam int W_IDX   = 4;
    localparam int W_SIZE  = 15;
    localparam int N_COEF  = 12;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_PROJECT = 1'b1;

    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;

    typedef struct packed {
        logic               req_type;
        logic [W_IDX-1:0]   coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic               visible;
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
    } out_item_t;

endpackage

/* sv/ppts_div_cell.sv */
// One restoring-division step for two quotients side by side.
module ppts_div_cell
    import ppts_pkg::*;
#(
    parameter int NUM_W = 112,
    parameter int DEN_W = 50,
    parameter int CTX_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             valid_in,
    input  logic [NUM_W-1:0] numx_in,
    input  logic [NUM_W-1:0] numy_in,
    input  logic [DEN_W:0]   remx_in,
    input  logic [DEN_W:0]   remy_in,
    input  logic [DEN_W-1:0] den_in,
    input  logic [CTX_W-1:0] ctx_in,
    output logic             valid_out,
    output logic [NUM_W-1:0] numx_out,
    output logic [NUM_W-1:0] numy_out,
    output logic [DEN_W:0]   remx_out,
    output logic [DEN_W:0]   remy_out,
    output logic [DEN_W-1:0] den_out,
    output logic [CTX_W-1:0] ctx_out
);

    logic             valid_reg;
    logic [NUM_W-1:0] numx_reg, numy_reg, numx_next, numy_next;
    logic [DEN_W:0]   remx_reg, remy_reg, remx_next, remy_next;
    logic [DEN_W-1:0] den_reg;
    logic [CTX_W-1:0] ctx_reg;
    logic [DEN_W+1:0] shx, shy;

    // shift in the next numerator bit, subtract when it fits, shift in the quotient bit
    always_comb begin
        shx = {remx_in, numx_in[NUM_W-1]};
        shy = {remy_in, numy_in[NUM_W-1]};
        numx_next = {numx_in[NUM_W-2:0], 1'b0};
        numy_next = {numy_in[NUM_W-2:0], 1'b0};
        if (shx >= {2'b00, den_in}) begin
            shx = shx - {2'b00, den_in};
            numx_next[0] = 1'b1;
        end
        if (shy >= {2'b00, den_in}) begin
            shy = shy - {2'b00, den_in};
            numy_next[0] = 1'b1;
        end
        remx_next = shx[DEN_W:0];
        remy_next = shy[DEN_W:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_in;
        end
        numx_reg <= numx_next;
        numy_reg <= numy_next;
        remx_reg <= remx_next;
        remy_reg <= remy_next;
        den_reg  <= den_in;
        ctx_reg  <= ctx_in;
    end

    assign valid_out = valid_reg;
    assign numx_out  = numx_reg;
    assign numy_out  = numy_reg;
    assign remx_out  = remx_reg;
    assign remy_out  = remy_reg;
    assign den_out   = den_reg;
    assign ctx_out   = ctx_reg;

endmodule

/* sv/perspective_project_to_screen.sv */
// Channel   | Ports                  | Moves
// s_        | s_valid/s_ready/s_item | load or point item
// m_        | m_valid/m_ready/m_item | projected point
// apb       | psel..prdata           | screen_width, screen_height
// One item per cycle sustained unless a stall on m_ fills the skid buffer. A point's
// result passes through five product, sum and numerator stages, one division cell per
// numerator bit (79 cells for any FRAC_BITS) and the skid buffer.
// Loads write the coefficient bank when they enter and give no result.
// Reset clears the coefficients to zero and the sizes to 1920 by 1080.
// A stall on m_ stops the whole chain; a two-entry skid buffer at the end keeps
// s_ready registered free of m_ready.
module perspective_project_to_screen
    import ppts_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int HALF_W = W_SIZE + FRAC_BITS - 1;     // half size bits
    localparam int DOT_W  = 65 - FRAC_BITS;             // three floor-products + c3
    localparam int MAG_W  = DOT_W;
    localparam int NUM_W  = MAG_W + HALF_W;             // |dot| * half
    localparam int DEN_W  = DOT_W - 1;                  // w is positive
    localparam int CTX_W  = 2 + HALF_W + HALF_W + 1 + 1;
    localparam int LO_W   = (MAG_W + 1) / 2;            // low part of |dot|
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PLO_W  = LO_W + HALF_W;
    localparam int PHI_W  = HI_W + HALF_W;
    localparam logic [DOT_W-1:0] THRESH = DOT_W'((64'd1 << FRAC_BITS) / 100);

    // ---------------- configuration
    logic [W_SIZE-1:0] width_reg, height_reg;
    logic              wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= W_SIZE'(1920);
            height_reg <= W_SIZE'(1080);
        end else if (wr_en) begin
            if (paddr[2] == REG_SCREEN_HEIGHT[0]) begin
                height_reg <= pwdata[W_SIZE-1:0];
            end else begin
                width_reg <= pwdata[W_SIZE-1:0];
            end
        end
    end
    always_comb begin
        case (paddr[2])
            REG_SCREEN_WIDTH[0]:  prdata = {17'd0, width_reg};
            REG_SCREEN_HEIGHT[0]: prdata = {17'd0, height_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline enable
    logic advance;
    logic [1:0] sk_cnt_reg;
    // chain moves only when skid buffer has room for everything in flight at its mouth
    assign advance = (sk_cnt_reg != 2'd2);
    assign s_ready = advance;

    logic s_acc;
    assign s_acc = s_valid && s_ready;

    // ---------------- coefficient bank
    logic signed [31:0] coef_reg [N_COEF];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N_COEF; i++) coef_reg[i] <= '0;
        end else if (s_acc && s_item.req_type == REQ_LOAD
                     && s_item.coef_index < W_IDX'(N_COEF)) begin
            coef_reg[s_item.coef_index] <= s_item.coef_value;
        end
    end

    // ---------------- stage 1: nine products
    logic               p1_v_reg;
    logic signed [63:0] prod_reg [9];
    logic signed [31:0] off_reg  [3];
    logic [HALF_W-1:0]  hw1_reg, hh1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
        end else if (advance) begin
            p1_v_reg <= s_acc && s_item.req_type == REQ_PROJECT;
        end
        if (advance) begin
            for (int r = 0; r < 3; r++) begin
                prod_reg[3*r]   <= 64'(coef_reg[4*r])   * 64'(s_item.pos_x);
                prod_reg[3*r+1] <= 64'(coef_reg[4*r+1]) * 64'(s_item.pos_y);
                prod_reg[3*r+2] <= 64'(coef_reg[4*r+2]) * 64'(s_item.pos_z);
                off_reg[r]      <= coef_reg[4*r+3];
            end
            hw1_reg <= {width_reg, {(FRAC_BITS-1){1'b0}}};
            hh1_reg <= {height_reg, {(FRAC_BITS-1){1'b0}}};
        end
    end

    // ---------------- stage 2: dot sums (arithmetic shift is floor)
    logic                    p2_v_reg;
    logic signed [DOT_W-1:0] dot_reg [3];
    logic [HALF_W-1:0]       hw2_reg, hh2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_v_reg <= 1'b0;
        end else if (advance) begin
            p2_v_reg <= p1_v_reg;
        end
        if (advance) begin
            for (int r = 0; r < 3; r++) begin
                dot_reg[r] <= DOT_W'(prod_reg[3*r] >>> FRAC_BITS)
                            + DOT_W'(prod_reg[3*r+1] >>> FRAC_BITS)
                            + DOT_W'(prod_reg[3*r+2] >>> FRAC_BITS)
                            + DOT_W'(off_reg[r]);
            end
            hw2_reg <= hw1_reg;
            hh2_reg <= hh1_reg;
        end
    end

    // ---------------- stage 3: visibility, magnitudes
    logic              p3_v_reg, vis3_reg, negx3_reg, negy3_reg;
    logic [MAG_W-1:0]  magx_reg, magy_reg;
    logic [DEN_W-1:0]  den3_reg;
    logic [HALF_W-1:0] hw3_reg, hh3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_v_reg <= 1'b0;
        end else if (advance) begin
            p3_v_reg <= p2_v_reg;
        end
        if (advance) begin
            vis3_reg  <= dot_reg[2] > $signed(THRESH);
            negx3_reg <= dot_reg[0][DOT_W-1];
            negy3_reg <= dot_reg[1][DOT_W-1];
            magx_reg  <= dot_reg[0][DOT_W-1] ? MAG_W'(-dot_reg[0]) : MAG_W'(dot_reg[0]);
            magy_reg  <= dot_reg[1][DOT_W-1] ? MAG_W'(-dot_reg[1]) : MAG_W'(dot_reg[1]);
            den3_reg  <= dot_reg[2][DEN_W-1:0];
            hw3_reg   <= hw2_reg;
            hh3_reg   <= hh2_reg;
        end
    end

    // ---------------- stage 4: partial numerators (about 25 x 30 each)
    logic              p4a_v_reg;
    logic [PLO_W-1:0]  plox_reg, ploy_reg;
    logic [PHI_W-1:0]  phix_reg, phiy_reg;
    logic [DEN_W-1:0]  den4a_reg;
    logic [CTX_W-1:0]  ctx4a_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4a_v_reg <= 1'b0;
        end else if (advance) begin
            p4a_v_reg <= p3_v_reg;
        end
        if (advance) begin
            plox_reg  <= PLO_W'(magx_reg[LO_W-1:0]) * PLO_W'(hw3_reg);
            phix_reg  <= PHI_W'(magx_reg[MAG_W-1:LO_W]) * PHI_W'(hw3_reg);
            ploy_reg  <= PLO_W'(magy_reg[LO_W-1:0]) * PLO_W'(hh3_reg);
            phiy_reg  <= PHI_W'(magy_reg[MAG_W-1:LO_W]) * PHI_W'(hh3_reg);
            den4a_reg <= vis3_reg ? den3_reg : DEN_W'(1);
            ctx4a_reg <= {vis3_reg, negx3_reg, negy3_reg, hw3_reg, hh3_reg, 1'b0};
        end
    end

    // ---------------- stage 5: numerators
    logic              p4_v_reg;
    logic [NUM_W-1:0]  numx4_reg, numy4_reg;
    logic [DEN_W-1:0]  den4_reg;
    logic [CTX_W-1:0]  ctx4_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_v_reg <= 1'b0;
        end else if (advance) begin
            p4_v_reg <= p4a_v_reg;
        end
        if (advance) begin
            numx4_reg <= (NUM_W'(phix_reg) << LO_W) + NUM_W'(plox_reg);
            numy4_reg <= (NUM_W'(phiy_reg) << LO_W) + NUM_W'(ploy_reg);
            den4_reg  <= den4a_reg;
            ctx4_reg  <= ctx4a_reg;
        end
    end

    // ---------------- chain of division cells
    logic             cv   [NUM_W+1];
    logic [NUM_W-1:0] cnx  [NUM_W+1];
    logic [NUM_W-1:0] cny  [NUM_W+1];
    logic [DEN_W:0]   crx  [NUM_W+1];
    logic [DEN_W:0]   cry  [NUM_W+1];
    logic [DEN_W-1:0] cd   [NUM_W+1];
    logic [CTX_W-1:0] cc   [NUM_W+1];
    assign cv[0]  = p4_v_reg;
    assign cnx[0] = numx4_reg;
    assign cny[0] = numy4_reg;
    assign crx[0] = '0;
    assign cry[0] = '0;
    assign cd[0]  = den4_reg;
    assign cc[0]  = ctx4_reg;

    genvar g;
    generate
        for (g = 0; g < NUM_W; g++) begin : g_cell
            logic             v_o;
            logic [NUM_W-1:0] nx_o, ny_o;
            logic [DEN_W:0]   rx_o, ry_o;
            logic [DEN_W-1:0] d_o;
            logic [CTX_W-1:0] c_o;
            ppts_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .CTX_W(CTX_W)) u_cell (
                .aclk(aclk), .aresetn(aresetn),
                .valid_in(cv[g] && advance), .numx_in(cnx[g]), .numy_in(cny[g]),
                .remx_in(crx[g]), .remy_in(cry[g]), .den_in(cd[g]), .ctx_in(cc[g]),
                .valid_out(v_o), .numx_out(nx_o), .numy_out(ny_o),
                .remx_out(rx_o), .remy_out(ry_o), .den_out(d_o), .ctx_out(c_o)
            );
            // hold: while stalled, the mux below presents the output captured before the stall
            logic             hv_reg;
            logic [NUM_W-1:0] hnx_reg, hny_reg;
            logic [DEN_W:0]   hrx_reg, hry_reg;
            logic [DEN_W-1:0] hd_reg;
            logic [CTX_W-1:0] hc_reg;
            logic             stall_reg;
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    stall_reg <= 1'b0;
                    hv_reg    <= 1'b0;
                end else begin
                    stall_reg <= !advance;
                    if (!stall_reg) begin
                        hv_reg <= v_o;
                    end
                end
                if (!stall_reg) begin
                    hnx_reg <= nx_o; hny_reg <= ny_o;
                    hrx_reg <= rx_o; hry_reg <= ry_o;
                    hd_reg  <= d_o;  hc_reg  <= c_o;
                end
            end
            assign cv[g+1]  = stall_reg ? hv_reg  : v_o;
            assign cnx[g+1] = stall_reg ? hnx_reg : nx_o;
            assign cny[g+1] = stall_reg ? hny_reg : ny_o;
            assign crx[g+1] = stall_reg ? hrx_reg : rx_o;
            assign cry[g+1] = stall_reg ? hry_reg : ry_o;
            assign cd[g+1]  = stall_reg ? hd_reg  : d_o;
            assign cc[g+1]  = stall_reg ? hc_reg  : c_o;
        end
    endgenerate

    // ---------------- final: sign, offset, saturate, zero hidden points
    logic [NUM_W-1:0]   q;
    logic [CTX_W-1:0]   fc;
    logic               f_vis, f_nx, f_ny, bigx, bigy;
    logic [HALF_W-1:0]  f_hw, f_hh;
    logic signed [64:0] qx, qy, sx, sy;
    logic signed [31:0] outx, outy;
    assign q  = cnx[NUM_W];
    assign fc = cc[NUM_W];
    assign f_vis = fc[CTX_W-1];
    assign f_nx  = fc[CTX_W-2];
    assign f_ny  = fc[CTX_W-3];
    assign f_hw  = fc[CTX_W-4 -: HALF_W];
    assign f_hh  = fc[HALF_W:1];
    always_comb begin
        bigx = |(q >> 62);
        bigy = |(cny[NUM_W] >> 62);
        qx = 65'(q[61:0]);
        qy = 65'(cny[NUM_W][61:0]);
        if (f_nx) qx = -qx;
        if (f_ny) qy = -qy;
        sx = 65'(f_hw) + qx;
        sy = 65'(f_hh) - qy;
        if (bigx) outx = f_nx ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else if (sx > 65'sd2147483647) outx = 32'sh7fff_ffff;
        else if (sx < -65'sd2147483648) outx = 32'sh8000_0000;
        else outx = sx[31:0];
        if (bigy) outy = f_ny ? 32'sh7fff_ffff : 32'sh8000_0000;
        else if (sy > 65'sd2147483647) outy = 32'sh7fff_ffff;
        else if (sy < -65'sd2147483648) outy = 32'sh8000_0000;
        else outy = sy[31:0];
        if (!f_vis) begin
            outx = '0;
            outy = '0;
        end
    end

    logic      f_valid;
    out_item_t f_item;
    assign f_valid = cv[NUM_W] && advance;
    assign f_item  = '{visible: f_vis, screen_x: outx, screen_y: outy};

    // ---------------- skid buffer (two entries)
    out_item_t sk_reg [2];
    logic      push, pop;
    assign push = f_valid;
    assign pop  = m_valid && m_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sk_cnt_reg <= 2'd0;
        end else begin
            sk_cnt_reg <= sk_cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (pop) begin
            if (push && sk_cnt_reg == 2'd1) begin
                sk_reg[0] <= f_item;
            end else begin
                sk_reg[0] <= sk_reg[1];
            end
            if (push && sk_cnt_reg == 2'd2) begin
                sk_reg[1] <= f_item;
            end
        end else if (push) begin
            if (sk_cnt_reg == 2'd0) begin
                sk_reg[0] <= f_item;
            end else begin
                sk_reg[1] <= f_item;
            end
        end
    end
    assign m_valid = (sk_cnt_reg != 2'd0);
    assign m_item  = sk_reg[0];

    a_skid_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sk_cnt_reg != 2'd3) else $error("skid overflow");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        sk_cnt_reg == 2'd2 |-> !f_valid) else $error("push into full skid");
    a_hidden_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        f_valid && !f_vis |-> outx == 0 && outy == 0) else $error("hidden point nonzero");

endmodule

/* tb/sv/ppts_checker.sv */
module ppts_checker
    import ppts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_item,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          points_waiting,
    output int          points_seen,
    output int          visible_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam logic signed [63:0] DEPTH_MIN = (64'sd1 <<< FRAC) / 100;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    logic signed [31:0] coef [N_COEF];
    logic [W_SIZE-1:0]  width_px;
    logic [W_SIZE-1:0]  height_px;
    out_item_t          proj_q [$];

    assign points_waiting = proj_q.size();

    function automatic logic signed [63:0] row_dot(int r, logic signed [63:0] x,
                                                   logic signed [63:0] y,
                                                   logic signed [63:0] z);
        logic signed [63:0] c0, c1, c2, c3;
        c0 = coef[r*4];
        c1 = coef[r*4+1];
        c2 = coef[r*4+2];
        c3 = coef[r*4+3];
        return ((c0 * x) >>> FRAC) + ((c1 * y) >>> FRAC) + ((c2 * z) >>> FRAC) + c3;
    endfunction

    function automatic logic signed [31:0] screen_coord(logic signed [63:0] half,
                                                        logic signed [63:0] dot,
                                                        logic signed [63:0] w,
                                                        logic negate);
        logic [63:0]        mag;
        logic [127:0]       num, quot;
        logic signed [63:0] sq, sum;
        logic               neg;
        mag  = dot < 0 ? 64'(-dot) : 64'(dot);
        num  = {64'd0, mag} * {64'd0, 64'(half)};
        quot = num / {64'd0, 64'(w)};
        neg  = (dot < 0) != negate;
        if (quot >= (128'd1 << 62))
            return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        sq  = dot < 0 ? -$signed(quot[63:0]) : $signed(quot[63:0]);
        sum = negate ? half - sq : half + sq;
        if (sum > S32_MAX) return 32'sh7fff_ffff;
        if (sum < S32_MIN) return 32'sh8000_0000;
        return sum[31:0];
    endfunction

    function automatic out_item_t project_point(in_item_t it);
        out_item_t          r;
        logic signed [63:0] x, y, z, w, hw, hh;
        x = it.pos_x;
        y = it.pos_y;
        z = it.pos_z;
        r = '0;
        w = row_dot(2, x, y, z);
        if (w <= DEPTH_MIN)
            return r;
        hw = 64'(width_px) << (FRAC - 1);
        hh = 64'(height_px) << (FRAC - 1);
        r.visible  = 1'b1;
        r.screen_x = screen_coord(hw, row_dot(0, x, y, z), w, 1'b0);
        r.screen_y = screen_coord(hh, row_dot(1, x, y, z), w, 1'b1);
        return r;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            foreach (coef[i]) coef[i] = '0;
            width_px  = 15'd1920;
            height_px = 15'd1080;
            proj_q.delete();
            fail_count   = 0;
            points_seen  = 0;
            visible_seen = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == 3'(4 * REG_SCREEN_WIDTH))
                    width_px = pwdata[W_SIZE-1:0];
                else if (paddr == 3'(4 * REG_SCREEN_HEIGHT))
                    height_px = pwdata[W_SIZE-1:0];
            end
            if (s_valid && s_ready) begin
                if (s_item.req_type == REQ_LOAD) begin
                    if (s_item.coef_index < N_COEF)
                        coef[s_item.coef_index] = s_item.coef_value;
                end else begin
                    proj_q.push_back(project_point(s_item));
                end
            end
            if (m_valid && m_ready) begin
                if (proj_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $realtime, m_item);
                    fail_count++;
                end else begin
                    want = proj_q.pop_front();
                    points_seen++;
                    if (want.visible) visible_seen++;
                    if (m_item.visible !== want.visible) begin
                        $display("%0t: visible exp %0b got %0b", $realtime,
                                 want.visible, m_item.visible);
                        fail_count++;
                    end
                    if (m_item.screen_x !== want.screen_x) begin
                        $display("%0t: screen_x exp %h got %h", $realtime,
                                 want.screen_x, m_item.screen_x);
                        fail_count++;
                    end
                    if (m_item.screen_y !== want.screen_y) begin
                        $display("%0t: screen_y exp %h got %h", $realtime,
                                 want.screen_y, m_item.screen_y);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

/* tb/sv/tb_perspective_project_to_screen.sv */
module tb_perspective_project_to_screen;
    import ppts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count, points_waiting, points_seen, visible_seen;
    int settings_run;
    bit send_burst, drain_burst;
    int stall_left;

    perspective_project_to_screen dut (.*);

    ppts_checker chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_item, .m_valid, .m_ready, .m_item,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .fail_count, .points_waiting, .points_seen, .visible_seen
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("timeout");
        $display("tb_perspective_project_to_screen NOT OK");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stalls, none during a drain burst
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (drain_burst) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    task automatic send(in_item_t it);
        int gap;
        gap = send_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic load(logic [3:0] idx, logic signed [31:0] val);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom, 5'($urandom)});
        it.req_type   = REQ_LOAD;
        it.coef_index = idx;
        it.coef_value = val;
        send(it);
    endtask

    task automatic point(logic signed [31:0] x, logic signed [31:0] y,
                         logic signed [31:0] z);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom, 5'($urandom)});
        it.req_type = REQ_PROJECT;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        send(it);
    endtask

    // Let the pipeline empty before touching the size registers
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (points_waiting != 0);
        repeat (300) @(posedge aclk);
    endtask

    task automatic apb_write(logic [1:0] reg_idx, logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(4 * reg_idx);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_screen(int w, int h);
        settle();
        apb_write(REG_SCREEN_WIDTH, 32'(w) | ($urandom & 32'hffff_8000));
        apb_write(REG_SCREEN_HEIGHT, 32'(h) | ($urandom & 32'hffff_8000));
        settings_run++;
    endtask

    function automatic logic signed [31:0] rand_val(int span);
        if ($urandom_range(0, 9) < 2) return $urandom;
        return $signed(32'($urandom_range(0, 2 * span))) - span;
    endfunction

    task automatic random_phase(int n_items);
        int sent;
        sent = 0;
        send_burst = $urandom_range(0, 3) == 0;
        while (sent < n_items) begin
            // Fresh view matrix: depth row biased to sit in front of the camera
            for (int i = 0; i < N_COEF; i++) begin
                if (i == 11)
                    load(4'(i), $urandom_range(0, 9) < 8 ?
                         32'($urandom_range(0, 40 * 65536)) : rand_val(4 * 65536));
                else if (i == 10)
                    load(4'(i), 32'($urandom_range(0, 2 * 65536)));
                else
                    load(4'(i), rand_val(3 * 65536));
                if ($urandom_range(0, 19) == 0) load(4'($urandom_range(12, 15)), $urandom);
            end
            sent += 12;
            repeat ($urandom_range(8, 25)) begin
                if ($urandom_range(0, 19) == 0)
                    load(4'($urandom_range(0, 11)), rand_val(3 * 65536));
                point(rand_val(100 * 65536), rand_val(100 * 65536), rand_val(100 * 65536));
                sent++;
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        send_burst  = 1'b0;
        drain_burst = 1'b0;
        settings_run = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty matrix, identity view, depth threshold, extremes
        point(32'sh7fff_ffff, 32'sh8000_0000, ONE);
        load(4'd0, ONE);
        load(4'd5, ONE);
        load(4'd10, ONE);
        load(4'd12, 32'shffff_ffff);
        load(4'd15, 32'sh7fff_ffff);
        point(ONE / 2, -ONE / 2, ONE);
        point(ONE, ONE, 32'sd655);
        point(ONE, ONE, 32'sd656);
        point(ONE, ONE, -ONE);
        point(32'sh7fff_ffff, 32'sh8000_0000, 32'sd656);
        point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
        load(4'd0, 32'sh7fff_ffff);
        load(4'd1, 32'sh7fff_ffff);
        load(4'd2, 32'sh7fff_ffff);
        load(4'd3, 32'sh7fff_ffff);
        load(4'd4, 32'sh8000_0000);
        load(4'd7, 32'sh8000_0000);
        load(4'd11, -32'sd1000);
        point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sd1700);
        point(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
        point('0, '0, 32'sd1655);
        point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);

        set_screen(1920, 1080);
        random_phase(100);
        set_screen(1, 1);
        random_phase(80);
        set_screen(16384, 16384);
        drain_burst = 1'b1;
        random_phase(80);
        drain_burst = 1'b0;
        set_screen(0, 32767);
        random_phase(80);
        set_screen(1023, 767);
        random_phase(100);
        set_screen(640, 0);
        random_phase(80);
        settle();

        $display("%0d points checked, %0d visible, %0d screen settings",
                 points_seen, visible_seen, settings_run + 1);
        if (fail_count == 0) begin
            $display("tb_perspective_project_to_screen OK");
        end else begin
            $display("tb_perspective_project_to_screen NOT OK");
        end
        $finish;
    end
endmodule
